// ===== src/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int RANK_WIDTH  = 8;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int IDX_WIDTH   = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] value;
    logic [RANK_WIDTH-1:0]  rank;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none
module spq_cell (
  input  wire logic                           clk,
  input  wire spq_pkg::cell_cmd_t             cmd,
  input  wire logic                           occ,
  input  wire logic                           left_keep,
  input  wire logic [spq_pkg::VALUE_WIDTH-1:0] left_value,
  input  wire logic [spq_pkg::RANK_WIDTH-1:0]  left_rank,
  input  wire logic [spq_pkg::VALUE_WIDTH-1:0] right_value,
  input  wire logic [spq_pkg::RANK_WIDTH-1:0]  right_rank,
  output logic [spq_pkg::VALUE_WIDTH-1:0]      value,
  output logic [spq_pkg::RANK_WIDTH-1:0]       rank,
  output logic                                keep
);

  logic [spq_pkg::VALUE_WIDTH-1:0] value_next;
  logic [spq_pkg::RANK_WIDTH-1:0]  rank_next;

  // equal ranks stay ahead of the new word, so arrival order holds
  assign keep = occ && (rank >= cmd.rank);

  always_comb begin
    value_next = value;
    rank_next  = rank;
    if (cmd.push) begin
      if (!keep) begin
        if (left_keep) begin
          value_next = cmd.value;
          rank_next  = cmd.rank;
        end else begin
          value_next = left_value;
          rank_next  = left_rank;
        end
      end
    end else if (cmd.pop) begin
      value_next = right_value;
      rank_next  = right_rank;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    rank  <= rank_next;
  end

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
`default_nettype none
// Bounded priority queue of spq_pkg::DEPTH entries held in a row of compare-and-shift
// cells, highest rank at the front, equal ranks in arrival order. Each word is a push,
// a pop of the front entry or a clear, and yields one result word describing the queue
// afterwards. All cells compare the new rank in parallel and shift left or right
// together, so a word is accepted every cycle while the result register is empty
// or being taken. A push into a full queue and a pop on an empty one leave the
// queue unchanged and are flagged in status.
module sorted_priority_queue_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          op,
  input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] item_value,
  input  wire logic [spq_pkg::RANK_WIDTH-1:0]       item_rank,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic signed [spq_pkg::VALUE_WIDTH-1:0]    front_value,
  output logic signed [spq_pkg::VALUE_WIDTH-1:0]    back_value,
  output logic [spq_pkg::COUNT_WIDTH-1:0]           fill_level,
  output logic                                     is_empty
);

  localparam int N = spq_pkg::DEPTH;

  logic [spq_pkg::COUNT_WIDTH-1:0] count, count_next;
  logic [1:0]                      status_next;
  logic                            accept, full, empty;
  spq_pkg::cell_cmd_t              cmd;

  logic [spq_pkg::VALUE_WIDTH-1:0] cell_value [N];
  logic [spq_pkg::RANK_WIDTH-1:0]  cell_rank  [N];
  logic [N-1:0]                    cell_keep;
  logic [N-1:0]                    cell_occ;
  logic [spq_pkg::IDX_WIDTH-1:0]   back_idx;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == spq_pkg::COUNT_WIDTH'(N));
  assign empty    = (count == '0);

  always_comb begin
    cmd.push    = 1'b0;
    cmd.pop     = 1'b0;
    cmd.value   = item_value;
    cmd.rank    = item_rank;
    count_next  = count;
    status_next = spq_pkg::ST_DONE;
    if (accept) begin
      unique case (op)
        spq_pkg::OP_PUSH: begin
          if (full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            cmd.push   = 1'b1;
            count_next = count + 1'b1;
          end
        end
        spq_pkg::OP_POP: begin
          if (empty) begin
            status_next = spq_pkg::ST_EMPTY;
          end else begin
            cmd.pop    = 1'b1;
            count_next = count - 1'b1;
          end
        end
        spq_pkg::OP_CLEAR: count_next = '0;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                            lk;
      logic [spq_pkg::VALUE_WIDTH-1:0] lv, rv;
      logic [spq_pkg::RANK_WIDTH-1:0]  lr, rr;

      assign cell_occ[g] = (spq_pkg::COUNT_WIDTH'(g) < count);

      if (g == 0) begin : g_head
        // front cell sees a virtual neighbor that always stays
        assign lk = 1'b1;
        assign lv = cmd.value;
        assign lr = cmd.rank;
      end else begin : g_mid
        assign lk = cell_keep[g-1];
        assign lv = cell_value[g-1];
        assign lr = cell_rank[g-1];
      end

      if (g == N - 1) begin : g_tail
        assign rv = cell_value[g];
        assign rr = cell_rank[g];
      end else begin : g_body
        assign rv = cell_value[g+1];
        assign rr = cell_rank[g+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (cell_occ[g]),
        .left_keep   (lk),
        .left_value  (lv),
        .left_rank   (lr),
        .right_value (rv),
        .right_rank  (rr),
        .value       (cell_value[g]),
        .rank        (cell_rank[g]),
        .keep        (cell_keep[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      status    <= spq_pkg::ST_DONE;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
        status    <= status_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields read the row after the update; it holds still while the word waits
  assign back_idx    = spq_pkg::IDX_WIDTH'(count - 1'b1);
  assign fill_level  = count;
  assign is_empty    = empty;
  assign front_value = empty ? '0 : cell_value[0];
  assign back_value  = empty ? '0 : cell_value[back_idx];

endmodule
`default_nettype wire

// ===== src/spq_checker.sv =====
`default_nettype none
module spq_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [1:0]                          status,
  input wire logic signed [spq_pkg::VALUE_WIDTH-1:0] front_value,
  input wire logic signed [spq_pkg::VALUE_WIDTH-1:0] back_value,
  input wire logic [spq_pkg::COUNT_WIDTH-1:0]      fill_level,
  input wire logic                                is_empty
);

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (front_value == '0) && (back_value == '0) && (fill_level == '0))
    else $error("empty queue shows nonzero fields");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_FULL) |->
      (fill_level == spq_pkg::COUNT_WIDTH'(spq_pkg::DEPTH)))
    else $error("push dropped while not full");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_EMPTY) |-> is_empty)
    else $error("pop flagged on nonempty queue");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fill_level) && $stable(status))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .front_value (front_value),
  .back_value  (back_value),
  .fill_level  (fill_level),
  .is_empty    (is_empty)
);
`default_nettype wire
